/* rtl/core/sspc_pkg.sv */
// Shared types, constants and helper functions for the serpentine scan
// position controller. Used by every module under rtl/core.
`default_nettype none

package sspc_pkg;

    localparam int ANGLE_W    = 8;
    localparam int STEP_W     = 6;
    localparam int DIAM_W     = 9;
    localparam int DEPTH_W    = 15;
    localparam int RAW_W      = 16;
    localparam int OP_W       = 3;
    localparam int DIR_W      = 2;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int DELTA_W    = 9;
    // Signed working width for angle sums: covers -255 .. 510.
    localparam int CALC_W     = 11;

    localparam int QUEUE_DEPTH      = 2;
    localparam int CALIB_PERIOD_DEF = 100;

    localparam logic [ANGLE_W-1:0] ANGLE_HOME_RESET = 8'd90;
    localparam logic [ANGLE_W-1:0] SERVO_MIN_RESET  = 8'd0;
    localparam logic [ANGLE_W-1:0] SERVO_MAX_RESET  = 8'd180;
    localparam logic [STEP_W-1:0]  SCAN_STEP_RESET  = 6'd1;
    localparam logic [DEPTH_W-1:0] DEPTH_OPEN       = 15'h7FFF;

    typedef enum logic [OP_W-1:0] {
        OP_ABS_MOVE   = 3'd0,
        OP_REL_MOVE   = 3'd1,
        OP_START_SCAN = 3'd2,
        OP_SCAN_STEP  = 3'd3,
        OP_STOP_SCAN  = 3'd4,
        OP_SAMPLE     = 3'd5
    } op_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_LEFT  = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_UP    = 2'd3
    } dir_t;

    typedef enum logic [2:0] {
        CMD_ABS    = 3'd0,
        CMD_REL    = 3'd1,
        CMD_START  = 3'd2,
        CMD_STEP   = 3'd3,
        CMD_STOP   = 3'd4,
        CMD_SAMPLE = 3'd5,
        CMD_NOP    = 3'd6
    } cmd_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_MANUAL = 2'd0,
        MODE_HSCAN  = 2'd1,
        MODE_VSCAN  = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SERVO_MIN_H = 3'd0,
        CFG_SERVO_MAX_H = 3'd1,
        CFG_SERVO_MIN_V = 3'd2,
        CFG_SERVO_MAX_V = 3'd3,
        CFG_SCAN_STEP   = 3'd4
    } cfg_idx_t;

    // One classified command as it travels from the front end to the back end.
    typedef struct packed {
        cmd_t                       cmd;
        logic [ANGLE_W-1:0]         target_h;
        logic [ANGLE_W-1:0]         target_v;
        logic signed [DELTA_W-1:0]  delta_h;
        logic signed [DELTA_W-1:0]  delta_v;
        logic                       vertical;
        logic [ANGLE_W-1:0]         radius;
        logic [DEPTH_W-1:0]         depth;
        logic [RAW_W-1:0]           raw;
    } sspc_cmd_t;

    function automatic logic signed [CALC_W-1:0] widen(input logic [ANGLE_W-1:0] a);
        widen = $signed({{(CALC_W-ANGLE_W){1'b0}}, a});
    endfunction

    // Low limit checked first: an inverted pair yields lo below lo, else hi.
    function automatic logic [ANGLE_W-1:0] clamp_angle(
        input logic signed [CALC_W-1:0] x,
        input logic [ANGLE_W-1:0]       lo,
        input logic [ANGLE_W-1:0]       hi
    );
        logic signed [CALC_W-1:0] lo_s;
        logic signed [CALC_W-1:0] hi_s;
        lo_s = widen(lo);
        hi_s = widen(hi);
        if (x < lo_s) begin
            clamp_angle = lo;
        end else if (x > hi_s) begin
            clamp_angle = hi;
        end else begin
            clamp_angle = x[ANGLE_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/core/sspc_front.sv */
// Front end: decodes one input word into a classified command.
// Depends on sspc_pkg for the command record and code types.
`default_nettype none

module sspc_front (
    input  wire logic [sspc_pkg::OP_W-1:0]    op,
    input  wire logic [sspc_pkg::ANGLE_W-1:0] target_h,
    input  wire logic [sspc_pkg::ANGLE_W-1:0] target_v,
    input  wire logic [sspc_pkg::DIR_W-1:0]   direction,
    input  wire logic [sspc_pkg::ANGLE_W-1:0] amount,
    input  wire logic                         scan_kind,
    input  wire logic [sspc_pkg::DIAM_W-1:0]  scan_diameter,
    input  wire logic [sspc_pkg::DEPTH_W-1:0] window_depth,
    input  wire logic [sspc_pkg::RAW_W-1:0]   raw_distance,
    output sspc_pkg::sspc_cmd_t               cmd
);

    logic signed [sspc_pkg::DELTA_W-1:0] amt_pos;

    assign amt_pos = $signed({1'b0, amount});

    always_comb begin
        cmd          = '0;
        cmd.target_h = target_h;
        cmd.target_v = target_v;
        cmd.vertical = scan_kind;
        cmd.radius   = scan_diameter[sspc_pkg::DIAM_W-1:1];
        cmd.depth    = window_depth;
        cmd.raw      = raw_distance;

        unique case (direction)
            sspc_pkg::DIR_LEFT:  cmd.delta_h = -amt_pos;
            sspc_pkg::DIR_RIGHT: cmd.delta_h = amt_pos;
            sspc_pkg::DIR_DOWN:  cmd.delta_v = -amt_pos;
            sspc_pkg::DIR_UP:    cmd.delta_v = amt_pos;
            default:             cmd.delta_h = '0;
        endcase

        // Unused op codes pass through as no-operations.
        case (op)
            sspc_pkg::OP_ABS_MOVE:   cmd.cmd = sspc_pkg::CMD_ABS;
            sspc_pkg::OP_REL_MOVE:   cmd.cmd = sspc_pkg::CMD_REL;
            sspc_pkg::OP_START_SCAN: cmd.cmd = sspc_pkg::CMD_START;
            sspc_pkg::OP_SCAN_STEP:  cmd.cmd = sspc_pkg::CMD_STEP;
            sspc_pkg::OP_STOP_SCAN:  cmd.cmd = sspc_pkg::CMD_STOP;
            sspc_pkg::OP_SAMPLE:     cmd.cmd = sspc_pkg::CMD_SAMPLE;
            default:                 cmd.cmd = sspc_pkg::CMD_NOP;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/sspc_queue.sv */
// Short command queue between the front end and the back end.
// Depends on sspc_pkg for the command record and the queue depth.
`default_nettype none

module sspc_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  sspc_pkg::sspc_cmd_t push_data,
    output logic               full,
    input  wire logic          pop,
    output sspc_pkg::sspc_cmd_t pop_data,
    output logic               empty
);

    localparam int DEPTH = sspc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    sspc_pkg::sspc_cmd_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/sspc_back.sv */
// Back end: holds the servo limits and scan state, executes one queued
// command per cycle when not stalled by m_ready, into the output register.
// Depends on sspc_pkg for types, constants and the clamp function.
`default_nettype none

module sspc_back #(
    parameter int CALIB_PERIOD = sspc_pkg::CALIB_PERIOD_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [sspc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sspc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            q_empty,
    input  sspc_pkg::sspc_cmd_t                  q_data,
    output logic                                 q_pop,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [sspc_pkg::ANGLE_W-1:0]         m_pos_h,
    output logic [sspc_pkg::ANGLE_W-1:0]         m_pos_v,
    output logic                                 m_moved,
    output logic [sspc_pkg::DEPTH_W-1:0]         m_distance,
    output logic                                 m_calibrate,
    output logic [sspc_pkg::MODE_W-1:0]          m_mode
);

    localparam int AW    = sspc_pkg::ANGLE_W;
    localparam int CW    = sspc_pkg::CALC_W;
    localparam int DW    = sspc_pkg::DEPTH_W;
    localparam int CNT_W = $clog2(CALIB_PERIOD + 1);

    // Configuration registers.
    logic [AW-1:0] min_h_reg, max_h_reg, min_v_reg, max_v_reg;
    logic [sspc_pkg::STEP_W-1:0] step_reg;

    // Controller state.
    logic [AW-1:0] cur_h_reg, cur_h_next, cur_v_reg, cur_v_next;
    logic [AW-1:0] home_h_reg, home_h_next, home_v_reg, home_v_next;
    logic [AW-1:0] wmin_h_reg, wmin_h_next, wmax_h_reg, wmax_h_next;
    logic [AW-1:0] wmin_v_reg, wmin_v_next, wmax_v_reg, wmax_v_next;
    logic          sweep_pos_reg, sweep_pos_next;
    sspc_pkg::mode_t mode_reg, mode_next;
    logic [DW-1:0]    depth_reg, depth_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Output register.
    logic          m_valid_reg, m_valid_next;
    logic [AW-1:0] m_pos_h_reg, m_pos_v_reg;
    logic          m_moved_reg, m_moved_next;
    logic [DW-1:0] m_distance_reg, m_distance_next;
    logic          m_calibrate_reg, m_calibrate_next;
    sspc_pkg::mode_t m_mode_reg;

    // Datapath terms.
    logic signed [CW-1:0] cur_h_w, cur_v_w, stp_w, sweep_delta;
    logic signed [CW-1:0] rel_h, rel_v, rad_w;
    logic [AW-1:0]        win_lo_h, win_hi_h, win_lo_v, win_hi_v;
    logic signed [CW-1:0] try_h, try_v;
    logic                 turn_h, turn_v;
    logic signed [CW-1:0] scan_h, scan_v;
    logic                 scan_turn, scan_go;
    logic [CNT_W-1:0]     count_inc;
    logic                 calib_hit;
    logic [DW-1:0]        sample_dist;

    assign q_pop = !q_empty && (!m_valid_reg || m_ready);

    assign cur_h_w     = sspc_pkg::widen(cur_h_reg);
    assign cur_v_w     = sspc_pkg::widen(cur_v_reg);
    assign stp_w       = $signed({{(CW-sspc_pkg::STEP_W){1'b0}}, step_reg});
    assign sweep_delta = sweep_pos_reg ? stp_w : -stp_w;

    assign rel_h = cur_h_w + CW'(q_data.delta_h);
    assign rel_v = cur_v_w + CW'(q_data.delta_v);
    assign rad_w = sspc_pkg::widen(q_data.radius);

    assign win_lo_h = sspc_pkg::clamp_angle(cur_h_w - rad_w, min_h_reg, max_h_reg);
    assign win_hi_h = sspc_pkg::clamp_angle(cur_h_w + rad_w, min_h_reg, max_h_reg);
    assign win_lo_v = sspc_pkg::clamp_angle(cur_v_w - rad_w, min_v_reg, max_v_reg);
    assign win_hi_v = sspc_pkg::clamp_angle(cur_v_w + rad_w, min_v_reg, max_v_reg);

    assign try_h  = cur_h_w + sweep_delta;
    assign try_v  = cur_v_w + sweep_delta;
    assign turn_h = (try_h > sspc_pkg::widen(wmax_h_reg))
                 || (try_h < sspc_pkg::widen(wmin_h_reg));
    assign turn_v = (try_v > sspc_pkg::widen(wmax_v_reg))
                 || (try_v < sspc_pkg::widen(wmin_v_reg));

    // At the edge of a line the sweep reverses, which lands back on the
    // current position along the line, and the scan moves one step across.
    always_comb begin
        if (mode_reg == sspc_pkg::MODE_VSCAN) begin
            scan_turn = turn_v;
            scan_v    = turn_v ? cur_v_w : try_v;
            scan_h    = turn_v ? cur_h_w + stp_w : cur_h_w;
            scan_go   = scan_h <= sspc_pkg::widen(wmax_h_reg);
        end else begin
            scan_turn = turn_h;
            scan_h    = turn_h ? cur_h_w : try_h;
            scan_v    = turn_h ? cur_v_w + stp_w : cur_v_w;
            scan_go   = scan_v <= sspc_pkg::widen(wmax_v_reg);
        end
    end

    assign count_inc   = count_reg + 1'b1;
    assign calib_hit   = count_inc >= CNT_W'(CALIB_PERIOD);
    assign sample_dist = (q_data.raw < {1'b0, depth_reg}) ? q_data.raw[DW-1:0] : depth_reg;

    always_comb begin
        cur_h_next       = cur_h_reg;
        cur_v_next       = cur_v_reg;
        home_h_next      = home_h_reg;
        home_v_next      = home_v_reg;
        wmin_h_next      = wmin_h_reg;
        wmax_h_next      = wmax_h_reg;
        wmin_v_next      = wmin_v_reg;
        wmax_v_next      = wmax_v_reg;
        sweep_pos_next   = sweep_pos_reg;
        mode_next        = mode_reg;
        depth_next       = depth_reg;
        count_next       = count_reg;
        m_moved_next     = 1'b0;
        m_distance_next  = '0;
        m_calibrate_next = 1'b0;

        unique case (q_data.cmd)
            sspc_pkg::CMD_ABS: begin
                cur_h_next = sspc_pkg::clamp_angle(sspc_pkg::widen(q_data.target_h),
                                                   min_h_reg, max_h_reg);
                cur_v_next = sspc_pkg::clamp_angle(sspc_pkg::widen(q_data.target_v),
                                                   min_v_reg, max_v_reg);
            end
            sspc_pkg::CMD_REL: begin
                cur_h_next = sspc_pkg::clamp_angle(rel_h, min_h_reg, max_h_reg);
                cur_v_next = sspc_pkg::clamp_angle(rel_v, min_v_reg, max_v_reg);
            end
            sspc_pkg::CMD_START: begin
                home_h_next    = cur_h_reg;
                home_v_next    = cur_v_reg;
                mode_next      = q_data.vertical ? sspc_pkg::MODE_VSCAN
                                                 : sspc_pkg::MODE_HSCAN;
                depth_next     = q_data.depth;
                sweep_pos_next = 1'b1;
                wmin_h_next    = win_lo_h;
                wmax_h_next    = win_hi_h;
                wmin_v_next    = win_lo_v;
                wmax_v_next    = win_hi_v;
                // The corner is clamped again; this matters only when a limit
                // pair is inverted.
                cur_h_next = sspc_pkg::clamp_angle(sspc_pkg::widen(win_lo_h),
                                                   min_h_reg, max_h_reg);
                cur_v_next = sspc_pkg::clamp_angle(sspc_pkg::widen(win_lo_v),
                                                   min_v_reg, max_v_reg);
            end
            sspc_pkg::CMD_STEP: begin
                if (mode_reg != sspc_pkg::MODE_MANUAL) begin
                    if (scan_turn) begin
                        sweep_pos_next = !sweep_pos_reg;
                    end
                    if (scan_go) begin
                        cur_h_next   = sspc_pkg::clamp_angle(scan_h, min_h_reg, max_h_reg);
                        cur_v_next   = sspc_pkg::clamp_angle(scan_v, min_v_reg, max_v_reg);
                        m_moved_next = 1'b1;
                    end
                end
            end
            sspc_pkg::CMD_STOP: begin
                depth_next = sspc_pkg::DEPTH_OPEN;
                mode_next  = sspc_pkg::MODE_MANUAL;
                cur_h_next = sspc_pkg::clamp_angle(sspc_pkg::widen(home_h_reg),
                                                   min_h_reg, max_h_reg);
                cur_v_next = sspc_pkg::clamp_angle(sspc_pkg::widen(home_v_reg),
                                                   min_v_reg, max_v_reg);
            end
            sspc_pkg::CMD_SAMPLE: begin
                count_next       = calib_hit ? '0 : count_inc;
                m_calibrate_next = calib_hit;
                m_distance_next  = sample_dist;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (q_pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_h_reg <= sspc_pkg::SERVO_MIN_RESET;
            max_h_reg <= sspc_pkg::SERVO_MAX_RESET;
            min_v_reg <= sspc_pkg::SERVO_MIN_RESET;
            max_v_reg <= sspc_pkg::SERVO_MAX_RESET;
            step_reg  <= sspc_pkg::SCAN_STEP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sspc_pkg::CFG_SERVO_MIN_H: min_h_reg <= cfg_data;
                sspc_pkg::CFG_SERVO_MAX_H: max_h_reg <= cfg_data;
                sspc_pkg::CFG_SERVO_MIN_V: min_v_reg <= cfg_data;
                sspc_pkg::CFG_SERVO_MAX_V: max_v_reg <= cfg_data;
                sspc_pkg::CFG_SCAN_STEP:   step_reg  <= cfg_data[sspc_pkg::STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_h_reg     <= sspc_pkg::ANGLE_HOME_RESET;
            cur_v_reg     <= sspc_pkg::ANGLE_HOME_RESET;
            home_h_reg    <= sspc_pkg::ANGLE_HOME_RESET;
            home_v_reg    <= sspc_pkg::ANGLE_HOME_RESET;
            wmin_h_reg    <= '0;
            wmax_h_reg    <= '0;
            wmin_v_reg    <= '0;
            wmax_v_reg    <= '0;
            sweep_pos_reg <= 1'b1;
            mode_reg      <= sspc_pkg::MODE_MANUAL;
            depth_reg     <= sspc_pkg::DEPTH_OPEN;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (q_pop) begin
                cur_h_reg     <= cur_h_next;
                cur_v_reg     <= cur_v_next;
                home_h_reg    <= home_h_next;
                home_v_reg    <= home_v_next;
                wmin_h_reg    <= wmin_h_next;
                wmax_h_reg    <= wmax_h_next;
                wmin_v_reg    <= wmin_v_next;
                wmax_v_reg    <= wmax_v_next;
                sweep_pos_reg <= sweep_pos_next;
                mode_reg      <= mode_next;
                depth_reg     <= depth_next;
                count_reg     <= count_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_pos_h_reg     <= cur_h_next;
            m_pos_v_reg     <= cur_v_next;
            m_moved_reg     <= m_moved_next;
            m_distance_reg  <= m_distance_next;
            m_calibrate_reg <= m_calibrate_next;
            m_mode_reg      <= mode_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pos_h     = m_pos_h_reg;
    assign m_pos_v     = m_pos_v_reg;
    assign m_moved     = m_moved_reg;
    assign m_distance  = m_distance_reg;
    assign m_calibrate = m_calibrate_reg;
    assign m_mode      = m_mode_reg;

    a_moved_only_scanning: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_moved_reg |-> m_mode_reg != sspc_pkg::MODE_MANUAL)
        else $error("moved word reported outside a scan mode");

    a_calib_not_moved: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_calibrate_reg |-> !m_moved_reg)
        else $error("calibration word also flagged as a move");

    a_pop_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> m_valid_reg)
        else $error("executed command left no word in the output register");

    a_sample_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg < CNT_W'(CALIB_PERIOD))
        else $error("sample counter passed the calibration period");

endmodule

`default_nettype wire

/* rtl/core/serpentine_scan_position_controller_core.sv */
// Serpentine scan position controller: pan/tilt servo moves, raster scan
// stepping and range sample clamping. Built from sspc_front, sspc_queue and
// sspc_back; all types and constants come from sspc_pkg.
//
// Usage:
//   The s_ channel takes one command word per cycle while s_ready is high, and
//   every command returns exactly one result word on m_; both are valid/ready.
//   Servo limits and the scan step are written through cfg_wr_en, cfg_index
//   and cfg_data while no command is in flight.
//   A command is written into the queue when it is accepted, and the back
//   end executes it from there into the output register on the m_ channel.
//   Commands flow at one per cycle while the m_ channel is not stalled; the
//   back end executes each one, both clamps of a scan start included.
//   A two-word queue separates the decoder from the executing back end, so
//   s_ready stays high while the queue has room even when m_ready is low.
//   When the receiver stalls, the result word holds and the queue fills;
//   s_ready drops once two commands wait behind the held result.
//   Reset (aresetn low, synchronous) empties the queue and output register,
//   restores the servo limits to 0..180, the scan step to 1, the position
//   and home to 90/90, manual mode, an open depth limit and a zero sample
//   count.
`default_nettype none

module serpentine_scan_position_controller_core #(
    parameter int CALIB_PERIOD = sspc_pkg::CALIB_PERIOD_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [sspc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sspc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [sspc_pkg::OP_W-1:0]       s_op,
    input  wire logic [sspc_pkg::ANGLE_W-1:0]    s_target_h,
    input  wire logic [sspc_pkg::ANGLE_W-1:0]    s_target_v,
    input  wire logic [sspc_pkg::DIR_W-1:0]      s_direction,
    input  wire logic [sspc_pkg::ANGLE_W-1:0]    s_amount,
    input  wire logic                            s_scan_kind,
    input  wire logic [sspc_pkg::DIAM_W-1:0]     s_scan_diameter,
    input  wire logic [sspc_pkg::DEPTH_W-1:0]    s_window_depth,
    input  wire logic [sspc_pkg::RAW_W-1:0]      s_raw_distance,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [sspc_pkg::ANGLE_W-1:0]         m_pos_h,
    output logic [sspc_pkg::ANGLE_W-1:0]         m_pos_v,
    output logic                                 m_moved,
    output logic [sspc_pkg::DEPTH_W-1:0]         m_distance,
    output logic                                 m_calibrate,
    output logic [sspc_pkg::MODE_W-1:0]          m_mode
);

    sspc_pkg::sspc_cmd_t front_cmd;
    sspc_pkg::sspc_cmd_t queue_head;
    logic                q_full;
    logic                q_empty;
    logic                q_pop;
    logic                q_push;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    sspc_front u_front (
        .op            (s_op),
        .target_h      (s_target_h),
        .target_v      (s_target_v),
        .direction     (s_direction),
        .amount        (s_amount),
        .scan_kind     (s_scan_kind),
        .scan_diameter (s_scan_diameter),
        .window_depth  (s_window_depth),
        .raw_distance  (s_raw_distance),
        .cmd           (front_cmd)
    );

    sspc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (queue_head),
        .empty     (q_empty)
    );

    sspc_back #(
        .CALIB_PERIOD (CALIB_PERIOD)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_empty     (q_empty),
        .q_data      (queue_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pos_h     (m_pos_h),
        .m_pos_v     (m_pos_v),
        .m_moved     (m_moved),
        .m_distance  (m_distance),
        .m_calibrate (m_calibrate),
        .m_mode      (m_mode)
    );

endmodule

`default_nettype wire
